FILE: rtl/sle_pkg.sv
// sle_pkg: shared types and constants of the sequential list engine
// no dependencies; used by sle_cell and sequential_list_engine
package sle_pkg;

    // fixed widths of the request and result fields
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    // per-transaction command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic remove;
        logic clear;
    } cmd_t;

endpackage

FILE: rtl/sle_cell.sv
// sle_cell: one storage slot of the list chain, with its shift, compare and read logic
// depends on sle_pkg (cmd_t)
module sle_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int CMP_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sle_pkg::cmd_t         cmd,
    input  logic [CMP_W-1:0]      pidx,
    input  logic [CMP_W-1:0]      fill,
    input  logic [ELEM_WIDTH-1:0] key,
    input  logic [ELEM_WIDTH-1:0] left,
    input  logic [ELEM_WIDTH-1:0] right,
    input  logic                  hit_in,
    output logic                  hit_out,
    output logic                  first,
    output logic [ELEM_WIDTH-1:0] entry,
    output logic [ELEM_WIDTH-1:0] rd
);

    localparam logic [CMP_W-1:0] IDX_C  = CMP_W'(IDX);
    localparam logic [CMP_W-1:0] IDX_P1 = CMP_W'(IDX + 1);

    logic [ELEM_WIDTH-1:0] entry_reg;
    logic [ELEM_WIDTH-1:0] entry_next;
    logic                  match;

    // next slot content: shift up on insert, down on delete, zero on clear
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.clear)
        begin
            entry_next = '0;
        end
        else if (cmd.insert)
        begin
            if (IDX_C == pidx)
            begin
                entry_next = key;
            end
            else if ((IDX_C > pidx) && (IDX_C <= fill))
            begin
                entry_next = left;
            end
        end
        else if (cmd.remove)
        begin
            if (IDX_P1 == fill)
            begin
                entry_next = '0;
            end
            else if ((IDX_C >= pidx) && (IDX_P1 < fill))
            begin
                entry_next = right;
            end
        end
    end

    // slot register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    // compare within the fill and ripple the first-match flag to the next cell
    assign match   = (entry_reg == key) && (IDX_C < fill);
    assign first   = match && !hit_in;
    assign hit_out = hit_in || match;

    // read port: this slot answers when the position points at it
    assign rd    = (IDX_C == pidx) ? entry_reg : '0;
    assign entry = entry_reg;

endmodule

FILE: rtl/sequential_list_engine.sv
// sequential_list_engine: top level of the ordered list engine
// depends on sle_pkg and sle_cell
//
// Ordered list of up to CAPACITY entries held in a chain of register cells.
// One transaction is accepted per cycle whenever the result register is free
// or being taken in the same cycle; its result appears in the next cycle.
// Get, locate, insert, delete and clear all finish in the cycle that accepts them:
// every cell shifts and compares in parallel, and the first-match flag of
// locate ripples through the chain, which sets the longest path in the design.
module sequential_list_engine #(
    parameter int CAPACITY   = 32,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sle_pkg::OP_W-1:0]        op,
    input  logic [sle_pkg::POS_W-1:0]       position,
    input  logic signed [sle_pkg::DATA_W-1:0] value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            status,
    output logic signed [sle_pkg::DATA_W-1:0] elem_out,
    output logic [sle_pkg::POS_W-1:0]       found_at,
    output logic [sle_pkg::POS_W-1:0]       count,
    output logic                            is_empty
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((FILL_W > sle_pkg::POS_W) ? FILL_W : sle_pkg::POS_W) + 1;
    localparam int EXT_W  = (ELEM_WIDTH > sle_pkg::DATA_W) ? ELEM_WIDTH : sle_pkg::DATA_W;

    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic                          out_valid_reg;
    logic                          status_reg;
    logic                          status_next;
    logic [sle_pkg::DATA_W-1:0]    elem_reg;
    logic [sle_pkg::DATA_W-1:0]    elem_next;
    logic [sle_pkg::POS_W-1:0]     found_reg;
    logic [sle_pkg::POS_W-1:0]     found_next;
    logic [sle_pkg::POS_W-1:0]     found_w;

    logic                          exec;
    sle_pkg::cmd_t                 cmd;
    logic [CMP_W-1:0]              pos_c;
    logic [CMP_W-1:0]              fill_c;
    logic [CMP_W-1:0]              pidx;
    logic                          rd_ok;
    logic                          ins_ok;
    logic [EXT_W-1:0]              val_ext;
    logic [ELEM_WIDTH-1:0]         key;
    logic [ELEM_WIDTH-1:0]         rd_or;
    logic [EXT_W-1:0]              rd_ext;

    logic [ELEM_WIDTH-1:0]         entry_w [CAPACITY];
    logic [ELEM_WIDTH-1:0]         left_w  [CAPACITY];
    logic [ELEM_WIDTH-1:0]         right_w [CAPACITY];
    logic [ELEM_WIDTH-1:0]         rd_w    [CAPACITY];
    logic [CAPACITY:0]             hit_w;
    logic [CAPACITY-1:0]           first_w;

    // handshake: a new transaction enters whenever the result slot frees up
    assign in_stall = out_valid_reg && out_stall;
    assign exec     = in_valid && !in_stall;

    // request decode against the current fill
    assign pos_c   = CMP_W'(position);
    assign fill_c  = CMP_W'(fill_reg);
    assign pidx    = pos_c - CMP_W'(1);
    assign rd_ok   = (position != '0) && (pos_c <= fill_c);
    assign ins_ok  = (fill_c < CMP_W'(CAPACITY)) && (position != '0)
                     && (pos_c <= fill_c + CMP_W'(1));
    assign val_ext = EXT_W'($unsigned(value));
    assign key     = val_ext[ELEM_WIDTH-1:0];

    // chain of cells
    assign hit_w[0] = 1'b0;

    genvar g;
    for (g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign left_w[g] = '0;
        end
        else
        begin : g_link_left
            assign left_w[g] = entry_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_w[g] = '0;
        end
        else
        begin : g_link_right
            assign right_w[g] = entry_w[g+1];
        end

        sle_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .CMP_W      (CMP_W),
            .IDX        (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .pidx    (pidx),
            .fill    (fill_c),
            .key     (key),
            .left    (left_w[g]),
            .right   (right_w[g]),
            .hit_in  (hit_w[g]),
            .hit_out (hit_w[g+1]),
            .first   (first_w[g]),
            .entry   (entry_w[g]),
            .rd      (rd_w[g])
        );
    end

    // gather the read data and the first-match position from the cells
    always_comb
    begin
        rd_or   = '0;
        found_w = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rd_or = rd_or | rd_w[k];
            if (first_w[k])
            begin
                found_w = found_w | sle_pkg::POS_W'(k + 1);
            end
        end
    end

    assign rd_ext = EXT_W'(rd_or);

    // operation dispatch and result values
    always_comb
    begin
        cmd         = '0;
        status_next = 1'b1;
        elem_next   = '0;
        found_next  = '0;
        fill_next   = fill_reg;
        case (sle_pkg::op_t'(op))
            sle_pkg::OP_GET:
            begin
                if (rd_ok)
                begin
                    status_next = 1'b0;
                    elem_next   = rd_ext[sle_pkg::DATA_W-1:0];
                end
            end
            sle_pkg::OP_LOCATE:
            begin
                status_next = 1'b0;
                found_next  = found_w;
            end
            sle_pkg::OP_INSERT:
            begin
                if (ins_ok)
                begin
                    cmd.insert  = exec;
                    status_next = 1'b0;
                    fill_next   = fill_reg + FILL_W'(1);
                end
            end
            sle_pkg::OP_DELETE:
            begin
                if (rd_ok)
                begin
                    cmd.remove  = exec;
                    status_next = 1'b0;
                    elem_next   = rd_ext[sle_pkg::DATA_W-1:0];
                    fill_next   = fill_reg - FILL_W'(1);
                end
            end
            sle_pkg::OP_CLEAR:
            begin
                cmd.clear   = exec;
                status_next = 1'b0;
                fill_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    // fill count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            status_reg <= status_next;
            elem_reg   <= elem_next;
            found_reg  <= found_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign elem_out  = elem_reg;
    assign found_at  = found_reg;
    assign count     = sle_pkg::POS_W'(fill_reg);
    assign is_empty  = (fill_reg == '0);

`ifndef SYNTHESIS
    // the fill never exceeds the capacity
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("fill count above capacity");

    // without an accepted transaction the fill holds
    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> $stable(fill_reg))
        else $error("fill changed without a transaction");

    // a transaction moves the fill by at most one, or empties the list
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> (fill_reg == $past(fill_reg)) || (fill_reg == '0)
                 || (fill_reg == $past(fill_reg) + FILL_W'(1))
                 || (fill_reg + FILL_W'(1) == $past(fill_reg)))
        else $error("fill moved by more than one entry");

    // every accepted transaction leaves a result behind
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("accepted transaction produced no result");
`endif

endmodule

FILE: tb/sequential_list_engine_tb.sv
// sequential_list_engine_tb: self-checking testbench of the ordered list engine
// depends on sle_pkg and sequential_list_engine; keeps a shadow list to predict
// every result and checks results in order under random input gaps and output stalls
`timescale 1ns / 100ps

module sequential_list_engine_tb;

    localparam int LIST_DEPTH = 32;
    localparam int CLK_HALF   = 4;
    localparam int POS_W      = sle_pkg::POS_W;
    localparam int DATA_W     = sle_pkg::DATA_W;
    localparam int OP_W       = sle_pkg::OP_W;

    // operation codes that the engine does not define
    localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

    // one result of the list engine
    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] elem;
        logic [POS_W-1:0]  found_at;
        logic [POS_W-1:0]  count;
        logic              is_empty;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic                     status;
    logic signed [DATA_W-1:0] elem_out;
    logic [POS_W-1:0]         found_at;
    logic [POS_W-1:0]         count;
    logic                     is_empty;

    // shadow copy of the list
    logic [DATA_W-1:0] shadow_entries [LIST_DEPTH];
    int                shadow_fill;

    list_result_t pending_results [$];
    int           error_count;
    int           results_seen;
    int           op_tally [8];
    int           full_hits;

    // sender and receiver pacing controls
    int sender_gap_max;
    int burst_left;
    int hold_request;

    sequential_list_engine #(
        .CAPACITY   (LIST_DEPTH),
        .ELEM_WIDTH (DATA_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .elem_out  (elem_out),
        .found_at  (found_at),
        .count     (count),
        .is_empty  (is_empty)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // apply one request to the shadow list and return its result
    function automatic list_result_t list_apply(input logic [OP_W-1:0] req_op,
                                                input logic [POS_W-1:0] req_pos,
                                                input logic [DATA_W-1:0] req_val);
        list_result_t r;
        int           p;
        int           k;
        r        = '0;
        r.status = 1'b1;
        p        = req_pos;
        case (req_op)
            sle_pkg::OP_GET:
            begin
                if (p >= 1 && p <= shadow_fill)
                begin
                    r.elem   = shadow_entries[p-1];
                    r.status = 1'b0;
                end
            end
            sle_pkg::OP_LOCATE:
            begin
                r.status = 1'b0;
                for (k = 0; k < shadow_fill; k++)
                    if (r.found_at == '0 && shadow_entries[k] == req_val)
                        r.found_at = POS_W'(k + 1);
            end
            sle_pkg::OP_INSERT:
            begin
                if (shadow_fill < LIST_DEPTH && p >= 1 && p <= shadow_fill + 1)
                begin
                    for (k = shadow_fill; k >= p; k--)
                        shadow_entries[k] = shadow_entries[k-1];
                    shadow_entries[p-1] = req_val;
                    shadow_fill++;
                    r.status = 1'b0;
                end
            end
            sle_pkg::OP_DELETE:
            begin
                if (p >= 1 && p <= shadow_fill)
                begin
                    r.elem = shadow_entries[p-1];
                    for (k = p; k < shadow_fill; k++)
                        shadow_entries[k-1] = shadow_entries[k];
                    shadow_entries[shadow_fill-1] = '0;
                    shadow_fill--;
                    r.status = 1'b0;
                end
            end
            sle_pkg::OP_CLEAR:
            begin
                for (k = 0; k < LIST_DEPTH; k++)
                    shadow_entries[k] = '0;
                shadow_fill = 0;
                r.status    = 1'b0;
            end
            default:
            begin
                r.status = 1'b1;
            end
        endcase
        r.count    = POS_W'(shadow_fill);
        r.is_empty = (shadow_fill == 0);
        return r;
    endfunction

    // burst and gap pacing of the sender
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // offer one transaction and hold it until accepted
    task automatic send_request(input logic [OP_W-1:0] req_op,
                                input logic [POS_W-1:0] req_pos,
                                input logic [DATA_W-1:0] req_val);
        list_result_t expected;
        op       <= req_op;
        position <= req_pos;
        value    <= req_val;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (req_op == sle_pkg::OP_INSERT && shadow_fill == LIST_DEPTH)
            full_hits++;
        expected = list_apply(req_op, req_pos, req_val);
        pending_results.push_back(expected);
        op_tally[req_op]++;
        pace_sender();
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // value picker with a bias toward the extremes
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // locate target: mostly a value present in the list
    function automatic logic [DATA_W-1:0] pick_target();
        if (shadow_fill > 0 && $urandom_range(0, 9) < 6)
            return shadow_entries[$urandom_range(0, shadow_fill - 1)];
        return ($urandom_range(0, 3) == 0) ? '0 : pick_value();
    endfunction

    // position for get and delete: mostly within the fill
    function automatic logic [POS_W-1:0] pick_read_pos();
        if ($urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(1, (shadow_fill > 0) ? shadow_fill : 1));
        return POS_W'($urandom_range(0, 63));
    endfunction

    // position for insert: mostly 1..fill+1
    function automatic logic [POS_W-1:0] pick_insert_pos();
        if ($urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(1, shadow_fill + 1));
        return POS_W'($urandom_range(0, 63));
    endfunction

    // edge cases on an empty, a short and a cleared list
    task automatic test_directed();
        send_request(sle_pkg::OP_GET, 6'd0, '0);
        send_request(sle_pkg::OP_GET, 6'd1, '0);
        send_request(sle_pkg::OP_DELETE, 6'd1, '0);
        send_request(sle_pkg::OP_LOCATE, 6'd0, '0);
        send_request(sle_pkg::OP_INSERT, 6'd0, 32'h1234_5678);
        send_request(sle_pkg::OP_INSERT, 6'd2, 32'h1234_5678);
        send_request(sle_pkg::OP_INSERT, 6'd1, 32'h8000_0000);
        send_request(sle_pkg::OP_INSERT, 6'd2, 32'h7fff_ffff);
        send_request(sle_pkg::OP_INSERT, 6'd1, 32'hffff_ffff);
        send_request(sle_pkg::OP_INSERT, 6'd63, 32'h5555_aaaa);
        send_request(sle_pkg::OP_GET, 6'd3, '0);
        send_request(sle_pkg::OP_GET, 6'd4, '0);
        send_request(sle_pkg::OP_LOCATE, 6'd63, 32'hffff_ffff);
        send_request(sle_pkg::OP_LOCATE, 6'd0, 32'h7fff_ffff);
        send_request(sle_pkg::OP_LOCATE, 6'd0, 32'h0000_0000);
        send_request(sle_pkg::OP_DELETE, 6'd2, '0);
        send_request(sle_pkg::OP_DELETE, 6'd0, '0);
        send_request(sle_pkg::OP_DELETE, 6'd63, '0);
        send_request(OP_RSVD_LO, 6'd63, 32'hffff_ffff);
        send_request(OP_RSVD_MID, 6'd1, 32'h0000_0000);
        send_request(OP_RSVD_HI, 6'd2, 32'haaaa_5555);
        send_request(sle_pkg::OP_CLEAR, 6'd63, 32'hffff_ffff);
        send_request(sle_pkg::OP_GET, 6'd1, '0);
        // freed slots hold zero but lie outside the fill
        send_request(sle_pkg::OP_LOCATE, 6'd0, 32'h0000_0000);
        wait_for_drain();
    endtask

    // fill to capacity, then probe the full list and its ends
    task automatic test_full_list();
        send_request(sle_pkg::OP_CLEAR, 6'd0, '0);
        while (shadow_fill < LIST_DEPTH)
            send_request(sle_pkg::OP_INSERT, POS_W'($urandom_range(1, shadow_fill + 1)),
                         pick_value());
        send_request(sle_pkg::OP_INSERT, 6'd33, pick_value());
        send_request(sle_pkg::OP_INSERT, 6'd1, pick_value());
        send_request(sle_pkg::OP_GET, 6'd1, '0);
        send_request(sle_pkg::OP_GET, 6'd32, '0);
        send_request(sle_pkg::OP_GET, 6'd33, '0);
        send_request(sle_pkg::OP_LOCATE, 6'd0, shadow_entries[LIST_DEPTH-1]);
        send_request(sle_pkg::OP_DELETE, 6'd33, '0);
        send_request(sle_pkg::OP_DELETE, 6'd32, '0);
        send_request(sle_pkg::OP_DELETE, 6'd1, '0);
        send_request(sle_pkg::OP_INSERT, 6'd32, pick_value());
        send_request(sle_pkg::OP_INSERT, 6'd31, pick_value());
        send_request(sle_pkg::OP_GET, 6'd31, '0);
        while (shadow_fill > 0)
            send_request(sle_pkg::OP_DELETE, POS_W'($urandom_range(1, shadow_fill)), '0);
        send_request(sle_pkg::OP_DELETE, 6'd1, '0);
        wait_for_drain();
    endtask

    // random mix with phases that grow, shrink or churn the list
    task automatic test_random_ops(input int n_items);
        int i;
        int mode;
        int roll;
        int ins_w;
        int del_w;
        int clr_w;
        mode = 0;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 60 == 0)
                mode = $urandom_range(0, 2);
            if (i % 100 == 0)
                sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
            ins_w = (mode == 0) ? 50 : (mode == 1) ? 15 : 30;
            del_w = (mode == 0) ? 15 : (mode == 1) ? 50 : 30;
            clr_w = (mode == 2) ? 2 : 0;
            roll  = $urandom_range(0, 99);
            if (roll < ins_w)
                send_request(sle_pkg::OP_INSERT, pick_insert_pos(), pick_value());
            else if (roll < ins_w + del_w)
                send_request(sle_pkg::OP_DELETE, pick_read_pos(), $urandom);
            else if (roll < ins_w + del_w + clr_w)
                send_request(sle_pkg::OP_CLEAR, POS_W'($urandom_range(0, 63)), $urandom);
            else if (roll < ins_w + del_w + clr_w + 2)
                send_request(OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)),
                             POS_W'($urandom_range(0, 63)), $urandom);
            else if ($urandom_range(0, 1) == 0)
                send_request(sle_pkg::OP_GET, pick_read_pos(), $urandom);
            else
                send_request(sle_pkg::OP_LOCATE, POS_W'($urandom_range(0, 63)),
                             pick_target());
        end
        wait_for_drain();
    endtask

    // long output hold while the sender keeps offering
    task automatic test_output_hold();
        int i;
        sender_gap_max = 0;
        hold_request   = 80;
        for (i = 0; i < 30; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_request(sle_pkg::OP_INSERT, pick_insert_pos(), pick_value());
            else
                send_request(sle_pkg::OP_GET, pick_read_pos(), '0);
        end
        wait_for_drain();
    endtask

    // receiver stall pattern, with a long hold on request
    initial
    begin : stall_pattern
        int hold_left;
        int pattern_mode;
        int cycle_no;
        out_stall    = 1'b0;
        hold_left    = 0;
        pattern_mode = 0;
        cycle_no     = 0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no % 100 == 0)
                pattern_mode = $urandom_range(0, 3);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (pattern_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    2:       out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= ((cycle_no % 5) < 3);
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        list_result_t got;
        list_result_t expected;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{status, elem_out, found_at, count, is_empty};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display({"unexpected result at %0t: status %b elem %h",
                              " found_at %0d count %0d empty %b"},
                             $realtime, got.status, got.elem, got.found_at, got.count,
                             got.is_empty);
            end
            else
            begin
                expected = pending_results.pop_front();
                if (got !== expected)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display({"mismatch at %0t: expected status %b elem %h",
                                  " found_at %0d count %0d empty %b"},
                                 $realtime, expected.status, expected.elem,
                                 expected.found_at, expected.count, expected.is_empty);
                        $display({"                 actual   status %b elem %h",
                                  " found_at %0d count %0d empty %b"},
                                 got.status, got.elem, got.found_at, got.count,
                                 got.is_empty);
                    end
                end
            end
        end
    end

    // test sequence
    initial
    begin : main_sequence
        int k;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = '0;
        position       = '0;
        value          = '0;
        error_count    = 0;
        results_seen   = 0;
        full_hits      = 0;
        sender_gap_max = 4;
        burst_left     = 1;
        hold_request   = 0;
        shadow_fill    = 0;
        for (k = 0; k < LIST_DEPTH; k++)
            shadow_entries[k] = '0;
        for (k = 0; k < 8; k++)
            op_tally[k] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_list();
        test_output_hold();
        test_random_ops(1000);

        // let the last result settle
        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
            error_count += pending_results.size();

        $display({"ran %0d transactions (%0d get, %0d locate, %0d insert,",
                  " %0d delete, %0d clear, %0d bad op)"},
                 results_seen, op_tally[sle_pkg::OP_GET], op_tally[sle_pkg::OP_LOCATE],
                 op_tally[sle_pkg::OP_INSERT], op_tally[sle_pkg::OP_DELETE],
                 op_tally[sle_pkg::OP_CLEAR],
                 op_tally[OP_RSVD_LO] + op_tally[OP_RSVD_MID] + op_tally[OP_RSVD_HI]);
        $display("inserts into a full list: %0d, errors: %0d", full_hits, error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sequential_list_engine.sv
tb/sequential_list_engine_tb.sv
